// File: sv/sta_pkg.sv
// Shared widths, constants, reciprocal table and pipeline payload type for the sine unit.
`timescale 1ns / 1ps

package sta_pkg;

  localparam int ANG_W     = 24;  // input angle, Q4.20
  localparam int X_W       = 25;  // angle during reduction, one guard bit
  localparam int MAG_W     = 21;  // |reduced angle|, Q20, at most pi/2
  localparam int X2_W      = 32;  // x*x, Q30
  localparam int T_W       = 32;  // term magnitude / intermediate product, Q30
  localparam int SUM_W     = 33;  // signed running sum, Q30
  localparam int RCP_W     = 22;  // reciprocal, Q24
  localparam int OUT_W     = 18;  // result, Q2.16
  localparam int MAX_TERMS = 8;

  localparam logic signed [X_W-1:0] ANG_PI      = 25'sd3294199;
  localparam logic signed [X_W-1:0] HALF_PI     = 25'sd1647099;
  localparam logic signed [X_W-1:0] NEG_HALF_PI = -25'sd1647099;
  localparam logic signed [X_W-1:0] TWO_PI      = 25'sd6588397;

  // 1/(2i(2i+1)) in Q24, rounded to nearest
  function automatic logic [RCP_W-1:0] recip_q24(input int unsigned idx);
    logic [RCP_W-1:0] r;
    unique case (idx)
      1: r = 22'd2796203;
      2: r = 22'd838861;
      3: r = 22'd399458;
      4: r = 22'd233017;
      5: r = 22'd152520;
      6: r = 22'd107546;
      7: r = 22'd79892;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Payload of the polynomial section
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [T_W-1:0]          term;
    logic [X2_W-1:0]         x2;
    logic                    x_neg;
    logic                    flip;
  } poly_t;

endpackage

// File: sv/sta_term.sv
// One Taylor term: term*x2, times reciprocal, then accumulate; three register stages.
`timescale 1ns / 1ps

module sta_term #(
  parameter int unsigned TERM_IDX = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sta_pkg::poly_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sta_pkg::poly_t out_data
);
  import sta_pkg::*;

  localparam logic [RCP_W-1:0] RECIP    = recip_q24(TERM_IDX);
  localparam bit               SUBTRACT = (TERM_IDX % 2) == 1;
  localparam int               MP_W     = T_W + X2_W;
  localparam int               RP_W     = T_W + RCP_W;

  logic  m_v_r, r_v_r, a_v_r;
  poly_t m_d_r, r_d_r, a_d_r;
  poly_t m_d_nxt, r_d_nxt, a_d_nxt;
  logic  m_rdy, r_rdy, a_rdy;

  logic [MP_W-1:0] m_prod, m_round;
  logic [RP_W-1:0] r_prod, r_round;

  assign a_rdy = !a_v_r || out_ready;
  assign r_rdy = !r_v_r || a_rdy;
  assign m_rdy = !m_v_r || r_rdy;

  // term * x2, Q30 x Q30 -> Q30, round half up
  always_comb begin
    m_prod       = MP_W'(in_data.term) * MP_W'(in_data.x2);
    m_round      = m_prod + (MP_W'(1) << 29);
    m_d_nxt      = in_data;
    m_d_nxt.term = m_round[30 +: T_W];
  end

  // times reciprocal, Q30 x Q24 -> Q30, round half up
  always_comb begin
    r_prod       = RP_W'(m_d_r.term) * RP_W'(RECIP);
    r_round      = r_prod + (RP_W'(1) << 23);
    r_d_nxt      = m_d_r;
    r_d_nxt.term = T_W'(r_round[RP_W-1:24]);
  end

  // alternating sign accumulate
  always_comb begin
    a_d_nxt = r_d_r;
    if (SUBTRACT) begin
      a_d_nxt.sum = r_d_r.sum - signed'(SUM_W'(r_d_r.term));
    end else begin
      a_d_nxt.sum = r_d_r.sum + signed'(SUM_W'(r_d_r.term));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      r_v_r <= 1'b0;
      a_v_r <= 1'b0;
    end else begin
      if (m_rdy) m_v_r <= in_valid;
      if (r_rdy) r_v_r <= m_v_r;
      if (a_rdy) a_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy && in_valid) m_d_r <= m_d_nxt;
    if (r_rdy && m_v_r)    r_d_r <= r_d_nxt;
    if (a_rdy && r_v_r)    a_d_r <= a_d_nxt;
  end

  assign in_ready  = m_rdy;
  assign out_valid = a_v_r;
  assign out_data  = a_d_r;

endmodule

// File: sv/sine_taylor_approx.sv
// Top level: pipelined fixed-point sine with range reduction and Taylor series.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready/in_angle: angle in radians, signed Q4.20.
//   Result channel out_valid/out_ready/out_sine_value: sine, signed Q2.16.
//   One transfer in gives exactly one transfer out, in order.
// Stages from input transfer to out_valid: three reduction stages, one squaring
//   stage, three stages per extra term (two multipliers and an accumulate), then a
//   rounding stage and the output register.
// Throughput: one angle per cycle while out_ready is high. Every stage holds its own valid bit and
//   loads whenever it is empty or its successor moves, so bubbles close up.
//   The slowest path is a 32x32 multiply in each term.
// Stall: when out_ready is low the output register holds; upstream stages keep
//   filling until the pipe is full, and only then in_ready drops. No item is
//   lost or duplicated.
// Reset (rst_n low, synchronous): all valid bits clear, so the pipe is empty;
//   payload registers are not reset.
// NUM_TERMS is taken as 1 to 8 (values outside are clamped).

module sine_taylor_approx #(
  parameter int NUM_TERMS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sta_pkg::ANG_W-1:0]    in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sta_pkg::OUT_W-1:0]    out_sine_value
);
  import sta_pkg::*;

  // term count actually built
  localparam int NT = (NUM_TERMS > MAX_TERMS) ? MAX_TERMS :
                      ((NUM_TERMS < 1) ? 1 : NUM_TERMS);
  localparam int SQ_W = 2 * MAG_W;
  localparam int RQ_W = SUM_W + 1 - 14;  // rounded Q16 magnitude

  localparam logic signed [OUT_W-1:0] OUT_MAX       = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN       = -18'sd131072;
  localparam logic signed [OUT_W-1:0] OUT_BOUND     = 18'sd102944;  // pi/2 in Q16
  localparam logic signed [OUT_W-1:0] NEG_OUT_BOUND = -18'sd102944;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic                  flip;
  } red_t;

  // one reduction step: above pi/2 take off pi and flip, below -pi/2 add 2*pi
  function automatic red_t red_step(input red_t a);
    red_t b;
    b = a;
    if (a.x > HALF_PI) begin
      b.x    = a.x - ANG_PI;
      b.flip = !a.flip;
    end else if (a.x < NEG_HALF_PI) begin
      b.x = a.x + TWO_PI;
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stages 1-3: range reduction, two steps per stage; stage 3 also takes |x|
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  red_t s1_d_r, s2_d_r;
  red_t s0_in, s1_d_nxt, s2_d_nxt, s3_red;

  logic [MAG_W-1:0]   s3_mag_r, s3_mag_nxt;
  logic               s3_xneg_r, s3_flip_r;
  logic [X_W-1:0]     s3_abs;

  poly_t              s4_d_r, s4_d_nxt;
  logic [SQ_W-1:0]    s4_sq, s4_sq_round;

  // term chain; element 0 is the squaring stage output
  logic  c_v   [NT];
  logic  c_rdy [NT];
  poly_t c_d   [NT];

  logic               f1_v_r, f1_rdy;
  logic [RQ_W-1:0]    f1_mag_r, f1_mag_nxt;
  logic               f1_neg_r, f1_neg_nxt;
  logic               f1_sneg;
  logic [SUM_W-1:0]   f1_smag;
  logic [SUM_W:0]     f1_round;

  logic               out_valid_r, f2_rdy;
  logic signed [OUT_W-1:0] out_sine_value_r, out_sine_value_nxt;

  always_comb begin
    s0_in.x    = X_W'(in_angle);
    s0_in.flip = 1'b0;
    s1_d_nxt   = red_step(red_step(s0_in));
    s2_d_nxt   = red_step(red_step(s1_d_r));
    s3_red     = red_step(red_step(s2_d_r));
    s3_abs     = s3_red.x[X_W-1] ? X_W'(-s3_red.x) : X_W'(s3_red.x);
    s3_mag_nxt = s3_abs[MAG_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: x*x in Q30 (round half up) and first term x in Q30
  // ---------------------------------------------------------------------------
  always_comb begin
    s4_sq          = SQ_W'(s3_mag_r) * SQ_W'(s3_mag_r);
    s4_sq_round    = s4_sq + SQ_W'(512);
    s4_d_nxt.x2    = s4_sq_round[10 +: X2_W];
    s4_d_nxt.term  = T_W'({s3_mag_r, 10'b0});
    s4_d_nxt.sum   = signed'(SUM_W'({s3_mag_r, 10'b0}));
    s4_d_nxt.x_neg = s3_xneg_r;
    s4_d_nxt.flip  = s3_flip_r;
  end

  assign f2_rdy = !out_valid_r || out_ready;
  assign f1_rdy = !f1_v_r || f2_rdy;
  assign s4_rdy = !s4_v_r || c_rdy[0];
  assign s3_rdy = !s3_v_r || s4_rdy;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;

  assign in_ready = s1_rdy;

  assign c_v[0]      = s4_v_r;
  assign c_d[0]      = s4_d_r;
  assign c_rdy[NT-1] = f1_rdy;

  // ---------------------------------------------------------------------------
  // Term stages: one sta_term per extra series term
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k < NT; k++) begin : g_term
    sta_term #(
      .TERM_IDX (k)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_v[k-1]),
      .in_ready  (c_rdy[k-1]),
      .in_data   (c_d[k-1]),
      .out_valid (c_v[k]),
      .out_ready (c_rdy[k]),
      .out_data  (c_d[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Final stages: sign of sum, Q30 -> Q16 round half away from zero, saturate
  // ---------------------------------------------------------------------------
  always_comb begin
    f1_sneg    = c_d[NT-1].sum[SUM_W-1];
    f1_smag    = f1_sneg ? SUM_W'(-c_d[NT-1].sum) : SUM_W'(c_d[NT-1].sum);
    f1_round   = (SUM_W+1)'(f1_smag) + (SUM_W+1)'(14'd8192);
    f1_mag_nxt = f1_round[SUM_W:14];
    f1_neg_nxt = (c_d[NT-1].x_neg ^ f1_sneg) ^ c_d[NT-1].flip;
  end

  always_comb begin
    if (f1_neg_r) begin
      if (f1_mag_r > RQ_W'(131072)) begin
        out_sine_value_nxt = OUT_MIN;
      end else begin
        out_sine_value_nxt = OUT_W'(-signed'((RQ_W+1)'(f1_mag_r)));
      end
    end else begin
      if (f1_mag_r > RQ_W'(131071)) begin
        out_sine_value_nxt = OUT_MAX;
      end else begin
        out_sine_value_nxt = OUT_W'(f1_mag_r);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      f1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r      <= in_valid;
      if (s2_rdy) s2_v_r      <= s1_v_r;
      if (s3_rdy) s3_v_r      <= s2_v_r;
      if (s4_rdy) s4_v_r      <= s3_v_r;
      if (f1_rdy) f1_v_r      <= c_v[NT-1];
      if (f2_rdy) out_valid_r <= f1_v_r;
    end
  end

  // payload, loaded only on a transfer into the stage
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) s1_d_r <= s1_d_nxt;
    if (s2_rdy && s1_v_r)   s2_d_r <= s2_d_nxt;
    if (s3_rdy && s2_v_r) begin
      s3_mag_r  <= s3_mag_nxt;
      s3_xneg_r <= s3_red.x[X_W-1];
      s3_flip_r <= s3_red.flip;
    end
    if (s4_rdy && s3_v_r) s4_d_r <= s4_d_nxt;
    if (f1_rdy && c_v[NT-1]) begin
      f1_mag_r <= f1_mag_nxt;
      f1_neg_r <= f1_neg_nxt;
    end
    if (f2_rdy && f1_v_r) out_sine_value_r <= out_sine_value_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sine_value = out_sine_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> s1_v_r)
    else $error("input transfer did not reach stage 1");

  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> s3_mag_r <= MAG_W'(HALF_PI))
    else $error("reduced angle outside pi/2");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sine_value_r <= OUT_BOUND) && (out_sine_value_r >= NEG_OUT_BOUND))
    else $error("sine result beyond pi/2 bound");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !f1_v_r && !s1_v_r)
    else $error("pipeline not empty after reset");

endmodule
